/* hdl/sdta_pkg.sv */
// Package: widths, character codes, controller states and control structs for the decimal printer.
`default_nettype none

package sdta_pkg;

    localparam int VALUE_W = 33;
    localparam int MAG_W   = 33;
    localparam int THR_W   = 34;
    localparam int NUM_POS = 10;
    localparam int POS_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [POS_W-1:0]  TOP_POS    = POS_W'(NUM_POS - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic step;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic pos_zero;
        logic digit_nz;
        logic started;
        logic out_free;
    } status_t;

    function automatic logic [THR_W-1:0] pow10(input logic [POS_W-1:0] k);
        logic [THR_W-1:0] p;
        case (k)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hdl/sdta_ctrl.sv */
// Controller: sequences the request through sign and decimal positions.
`default_nettype none

module sdta_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire sdta_pkg::status_t status,
    output sdta_pkg::cmd_t       cmd
);
    import sdta_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free && status.pos_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_DIGIT:
            begin
                cmd.step       = status.out_free;
                cmd.emit_digit = status.out_free
                               && (status.digit_nz || status.started || status.pos_zero);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/sdta_dp.sv */
// Datapath: magnitude, decimal position, digit extraction and output register.
`default_nettype none

module sdta_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic signed [sdta_pkg::VALUE_W-1:0]   value,
    input  wire sdta_pkg::cmd_t                        cmd,
    output sdta_pkg::status_t                          status,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sdta_pkg::CHAR_W-1:0]                char_code,
    output logic                                       last
);
    import sdta_pkg::*;

    logic [MAG_W-1:0]   rem_reg;
    logic [MAG_W-1:0]   rem_next;
    logic [POS_W-1:0]   pos_reg;
    logic               started_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [MAG_W-1:0]   mag;
    logic [THR_W-1:0]   rem_ext;
    logic [THR_W-1:0]   unit;
    logic [THR_W-1:0]   sub;
    logic [DIGIT_W-1:0] digit;
    logic [THR_W-1:0]   diff;

    assign mag     = value[VALUE_W-1] ? MAG_W'(-value) : MAG_W'(value);
    assign rem_ext = {1'b0, rem_reg};
    assign unit    = pow10(pos_reg);

    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int d = 1; d <= 9; d++)
        begin
            if (rem_ext >= THR_W'(unit * THR_W'(d)))
            begin
                digit = DIGIT_W'(d);
                sub   = THR_W'(unit * THR_W'(d));
            end
        end
    end

    assign diff     = rem_ext - sub;
    assign rem_next = diff[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg     <= TOP_POS;
                started_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                pos_reg <= pos_reg - POS_W'(1);
                if (cmd.emit_digit)
                begin
                    started_reg <= 1'b1;
                end
            end
            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= mag;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CHAR_ZERO + CHAR_W'(digit);
            last_reg <= (pos_reg == '0);
        end
    end

    assign status.neg      = value[VALUE_W-1];
    assign status.pos_zero = (pos_reg == '0);
    assign status.digit_nz = (digit != '0);
    assign status.started  = started_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

/* hdl/signed_decimal_to_ascii.sv */
// Top level: signed 33-bit value to decimal ASCII character run.
// Requests are accepted only while idle, so a new value waits until the sequencer is done;
// the digit sequencer walks all ten decimal positions, one per cycle while the output is
// free, after a sign state for negative values, and suppresses leading zeros.
// Output stalls hold the sequencer; one character leaves per cycle at most.
// Reset (rst_n, async, active low) returns to idle with no output pending.
`default_nettype none

module signed_decimal_to_ascii (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [sdta_pkg::VALUE_W-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [sdta_pkg::CHAR_W-1:0]              char_code,
    output logic                                     last
);
    import sdta_pkg::*;

    cmd_t    cmd;
    status_t status;

    sdta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sdta_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new request taken while one is in progress");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == CHAR_MINUS
                       || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)))
        else $error("illegal character on output");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == CHAR_MINUS |-> !last)
        else $error("sign marked as final character");

    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.pos_zero |=> in_ready)
        else $error("sequencer did not return to idle after units position");

    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit && status.pos_zero |=> out_valid && last)
        else $error("units digit not flagged as final");

endmodule

`default_nettype wire

/* tb/sv/signed_decimal_to_ascii_test.sv */
// Testbench: sends signed values to the decimal printer and checks every ASCII character.
`timescale 1ns / 100ps

module signed_decimal_to_ascii_test;
    import sdta_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 62;
    localparam int NUM_PHASES   = 4;
    localparam int NUM_DIRECTED = 21;

    localparam int KIND_FULL   = 0;
    localparam int KIND_DIGITS = 1;
    localparam int KIND_DECADE = 2;
    localparam int KIND_EDGE   = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [CHAR_W-1:0]         char_code;
    logic                      last;

    ascii_char_t expected_chars [$];

    int idle_pct          = 0;
    int stall_pct         = 0;
    int error_count       = 0;
    int requests_sent     = 0;
    int negative_requests = 0;
    int chars_checked     = 0;
    int quiet_cycles      = 0;

    int phase_idle  [0:NUM_PHASES-1] = '{0, 69, 0, 28};
    int phase_stall [0:NUM_PHASES-1] = '{0, 0, 69, 28};

    logic signed [VALUE_W-1:0] directed_values [0:NUM_DIRECTED-1] = '{
        33'sd0,          33'sd1,          -33'sd1,         33'sd9,
        33'sd10,         -33'sd10,        33'sd99,         33'sd100,
        -33'sd12345,     33'sd1000000000, 33'sd999999999,  -33'sd999999999,
        33'sd2147483647, -33'sd2147483648, 33'sd2147483648, -33'sd2147483649,
        33'sd4294967295, -33'sd4294967295, 33'h1_0000_0000, 33'sd1234567890,
        -33'sd987654321
    };

    string directed_text [0:NUM_DIRECTED-1] = '{
        "0",           "1",          "-1",          "9",
        "10",          "-10",        "",            "",
        "",            "1000000000", "",            "",
        "2147483647",  "-2147483648", "2147483648", "-2147483649",
        "4294967295",  "-4294967295", "-4294967296", "",
        ""
    };

    signed_decimal_to_ascii DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_decimal_text(input logic signed [VALUE_W-1:0] v);
        logic signed [VALUE_W:0] wide;
        logic [VALUE_W:0]        magnitude;
        logic [DIGIT_W-1:0]      digit_buf [0:NUM_POS-1];
        logic                    negative;
        int                      n_digits;
        wide      = v;
        negative  = wide < 0;
        magnitude = negative ? (VALUE_W + 1)'(-wide) : (VALUE_W + 1)'(wide);
        n_digits  = 0;
        do
        begin
            digit_buf[n_digits] = DIGIT_W'(magnitude % 10);
            magnitude           = magnitude / 10;
            n_digits++;
        end
        while (magnitude != 0 && n_digits < NUM_POS);
        if (negative)
            expected_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
        for (int i = n_digits - 1; i >= 0; i--)
            expected_chars.push_back('{code: CHAR_ZERO + CHAR_W'(digit_buf[i]), last: i == 0});
    endfunction

    function automatic void push_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_chars.push_back('{code: text[i], last: i == text.len() - 1});
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        longint span;
        longint mag;
        int     kind;
        logic   neg;
        logic   [VALUE_W-1:0] bits;
        kind = $urandom_range(KIND_EDGE, KIND_FULL);
        neg  = 1'($urandom_range(1));
        span = 1;
        mag  = 0;
        bits = {1'($urandom_range(1)), 32'($urandom)};
        case (kind)
            KIND_DIGITS:
            begin
                repeat ($urandom_range(10, 1)) span = span * 10;
                mag = longint'({$urandom, $urandom} % span);
                mag = neg ? mag % 64'd4294967297 : mag % 64'd4294967296;
            end
            KIND_DECADE:
            begin
                repeat ($urandom_range(9, 0)) span = span * 10;
                mag = span + longint'($urandom_range(2)) - 1;
            end
            KIND_EDGE:
            begin
                if ($urandom_range(1) == 1)
                    mag = 64'd2147483648 + longint'($urandom_range(2)) - 1;
                else
                    mag = 64'd4294967296 - longint'($urandom_range(2));
                if (!neg && mag == 64'd4294967296)
                    mag = 64'd4294967295;
            end
            default:
            begin
            end
        endcase
        if (kind != KIND_FULL)
            bits = VALUE_W'(neg ? -mag : mag);
        return bits;
    endfunction

    task automatic send_request(input logic signed [VALUE_W-1:0] v, input string text);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (text.len() != 0)
            push_typed_text(text);
        else
            push_decimal_text(v);
        requests_sent++;
        if (v < 0)
            negative_requests++;
        @(negedge clk);
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_chars.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character: char_code %0d, last %0b", char_code, last);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0d, got %0d", want.code, char_code);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(directed_values[i], directed_text[i]);
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_pause();
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            repeat (PHASE_ITEMS) send_request(random_value(), "");
        end
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Printed %0d values (%0d negative), %0d characters checked,",
                 requests_sent, negative_requests, chars_checked);
        $display("across free-running, sender-gap, receiver-stall and mixed pacing.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sdta_pkg.sv
hdl/sdta_ctrl.sv
hdl/sdta_dp.sv
hdl/signed_decimal_to_ascii.sv
tb/sv/signed_decimal_to_ascii_test.sv
